[sv/assert_macros.svh]
// Assertion macros for the commutator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/bsc_pkg.sv]
// Shared types, codes, constants and small functions of the sensorless commutator.
// No dependencies; imported by every module of the block.
package bsc_pkg;

	localparam int DEF_TIME_BITS   = 32;
	localparam int DEF_ADC_BITS    = 12;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int STEPS_PER_ROUND = 6;
	localparam int SUPPLY_GAIN     = 12;
	localparam int LOST_MAX        = 10;
	localparam int GOOD_MAX        = 6;

	localparam logic [31:0] RST_START_PERIOD = 32'd10000;
	localparam logic [7:0]  RST_START_ROUNDS = 8'd4;
	localparam logic [31:0] RST_INIT_ZC      = 32'd3000;
	localparam logic [31:0] RST_RUN_LIMIT    = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_TIMER = 2'd1,
		MODE_ADC   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		RUN_STOP   = 2'd0,
		RUN_START  = 2'd1,
		RUN_CLOSED = 2'd2
	} run_t;

	typedef enum logic [1:0] {
		EVT_NONE  = 2'd0,
		EVT_ZC    = 2'd1,
		EVT_LOST  = 2'd2,
		EVT_LIMIT = 2'd3
	} evt_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_PERIOD = 3'd0,
		REG_START_ROUNDS = 3'd1,
		REG_INIT_ZC      = 3'd2,
		REG_RUN_LIMIT    = 3'd3,
		REG_STIM_SELECT  = 3'd4,
		REG_SENSE_SELECT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] start_period;
		logic [7:0]  start_rounds;
		logic [31:0] initial_zc_period;
		logic [31:0] run_limit;
		logic [11:0] stim_select;
		logic [11:0] sense_select;
	} cfg_t;

	typedef struct packed {
		logic        drive_update;
		logic [2:0]  phase;
		logic [2:0]  high_side;
		logic        compare_valid;
		logic [31:0] compare_time;
		logic [1:0]  motor_state;
		logic [1:0]  event_code;
		logic [31:0] lost_total;
	} res_t;

	function automatic logic [2:0] next_phase(input logic [2:0] ph);
		return (ph >= 3'd6) ? 3'd1 : ph + 3'd1;
	endfunction

	function automatic logic [2:0] high_side_of(input logic [2:0] ph);
		logic [2:0] hs;
		unique case (ph)
			3'd1, 3'd2: hs = 3'b001;
			3'd3, 3'd4: hs = 3'b010;
			3'd5, 3'd6: hs = 3'b100;
			default:    hs = 3'b000;
		endcase
		return hs;
	endfunction

	function automatic logic [1:0] chan_of(input logic [11:0] sel, input logic [2:0] ph);
		logic [1:0] ch;
		unique case (ph)
			3'd2:    ch = sel[3:2];
			3'd3:    ch = sel[5:4];
			3'd4:    ch = sel[7:6];
			3'd5:    ch = sel[9:8];
			3'd6:    ch = sel[11:10];
			default: ch = sel[1:0];
		endcase
		return ch;
	endfunction

endpackage

[sv/bsc_cfg.sv]
// Configuration register file of the sensorless commutator.
// Depends on bsc_pkg for the register index codes, reset values and cfg_t.
module bsc_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [bsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output bsc_pkg::cfg_t                         cfg
);
	import bsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_period      <= RST_START_PERIOD;
			cfg_q.start_rounds      <= RST_START_ROUNDS;
			cfg_q.initial_zc_period <= RST_INIT_ZC;
			cfg_q.run_limit         <= RST_RUN_LIMIT;
			cfg_q.stim_select       <= '0;
			cfg_q.sense_select      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_PERIOD: cfg_q.start_period      <= cfg_data[31:0];
				REG_START_ROUNDS: cfg_q.start_rounds      <= cfg_data[7:0];
				REG_INIT_ZC:      cfg_q.initial_zc_period <= cfg_data[31:0];
				REG_RUN_LIMIT:    cfg_q.run_limit         <= cfg_data[31:0];
				REG_STIM_SELECT:  cfg_q.stim_select       <= cfg_data[11:0];
				REG_SENSE_SELECT: cfg_q.sense_select      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/bsc_core.sv]
// Commutation state and per-item next-state logic of the sensorless commutator.
// Depends on bsc_pkg and assert_macros.svh; state advances when the top level transfers an item.
`include "assert_macros.svh"

module bsc_core #(
	parameter int TIME_BITS = bsc_pkg::DEF_TIME_BITS,
	parameter int ADC_BITS  = bsc_pkg::DEF_ADC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsc_pkg::cfg_t        cfg,
	input  logic                 adv,
	input  logic [1:0]           mode,
	input  logic [TIME_BITS-1:0] now,
	input  logic [ADC_BITS-1:0]  volt_a,
	input  logic [ADC_BITS-1:0]  volt_b,
	input  logic [ADC_BITS-1:0]  volt_c,
	input  logic [ADC_BITS-1:0]  supply_sample,
	output bsc_pkg::res_t        res
);
	import bsc_pkg::*;

	localparam int SW = ADC_BITS + 4;

	typedef logic [TIME_BITS-1:0] tm_t;

	function automatic tm_t shrink(input tm_t p);
		logic [TIME_BITS+3:0] x;
		x = {p, 4'b0000} - {4'b0000, p};
		return x[TIME_BITS+3:4];
	endfunction

	function automatic logic is_earlier(input tm_t a, input tm_t b);
		tm_t d;
		d = a - b;
		return d[TIME_BITS-1];
	endfunction

	function automatic logic [ADC_BITS-1:0] sample_of(
		input logic [1:0] ch, input logic [ADC_BITS-1:0] s0, input logic [ADC_BITS-1:0] s1,
		input logic [ADC_BITS-1:0] s2, input logic [ADC_BITS-1:0] s3);
		logic [ADC_BITS-1:0] v;
		unique case (ch)
			2'd0:    v = s0;
			2'd1:    v = s1;
			2'd2:    v = s2;
			default: v = s3;
		endcase
		return v;
	endfunction

	run_t        run_q, run_d;
	logic [2:0]  phase_q, phase_d;
	logic [15:0] start_cnt_q, start_cnt_d;
	tm_t         open_q, open_d;
	tm_t         last_cmp_q, last_cmp_d;
	tm_t         zc_per_q, zc_per_d;
	tm_t         last_zc_q, last_zc_d;
	tm_t         win_open_q, win_open_d;
	tm_t         win_close_q, win_close_d;
	logic        falling_q, falling_d;
	logic        valid_seen_q, valid_seen_d;
	tm_t         last_valid_q, last_valid_d;
	logic [2:0]  good_q, good_d;
	logic [3:0]  lost_q, lost_d;
	logic [31:0] lost_sum_q, lost_sum_d;
	logic [31:0] zc_cnt_q, zc_cnt_d;

	tm_t                 p0, ct_start, ct_open, zc_init;
	tm_t                 zt, zc_sum, zc_new, eighth, wo_new, wc_new, ct_zc;
	logic [10:0]         rounds6;
	logic [15:0]         cnt_inc;
	logic                enter_closed;
	logic [ADC_BITS-1:0] stim, sense;
	logic [SW-1:0]       supply12;
	logic                qualified, cross_hit, late, in_win, lost_stop, at_limit;
	logic [3:0]          lost_inc;
	logic [2:0]          good_inc, phase_nx;
	logic [31:0]         zc_inc;

	logic       drive, cvalid, found;
	logic [2:0] drv_phase;
	evt_t       evt;
	tm_t        ct;

	assign p0           = TIME_BITS'(cfg.start_period);
	assign ct_start     = now + p0;
	assign ct_open      = last_cmp_q + open_q;
	assign zc_init      = TIME_BITS'(cfg.initial_zc_period);
	assign rounds6      = 11'(cfg.start_rounds) * 11'(STEPS_PER_ROUND);
	assign cnt_inc      = start_cnt_q + 16'd1;
	assign enter_closed = cnt_inc > 16'(rounds6);

	assign stim  = sample_of(chan_of(cfg.stim_select, phase_q),
		volt_a, volt_b, volt_c, supply_sample);
	assign sense = sample_of(chan_of(cfg.sense_select, phase_q),
		volt_a, volt_b, volt_c, supply_sample);
	assign supply12  = SW'(supply_sample) * SW'(SUPPLY_GAIN);
	assign qualified = SW'(stim) > supply12;
	assign cross_hit = ({sense, 1'b0} < {1'b0, stim}) != falling_q;

	assign late      = is_earlier(win_close_q, now);
	assign in_win    = !is_earlier(now, win_open_q);
	assign lost_inc  = lost_q + 4'd1;
	assign lost_stop = lost_inc > 4'(LOST_MAX);
	assign good_inc  = good_q + 3'd1;

	assign zt     = valid_seen_q ? ((now - last_valid_q) >> 1) + last_valid_q : now;
	assign zc_sum = (zc_per_q << 3) - zc_per_q + zt - last_zc_q;
	assign zc_new = zc_sum >> 3;
	assign eighth = zc_new >> 3;
	assign wo_new = zt + (eighth << 2) + eighth;
	assign wc_new = wo_new + zc_new;
	assign ct_zc  = zt + (zc_new >> 1);

	assign zc_inc   = zc_cnt_q + 32'd1;
	assign at_limit = zc_inc > cfg.run_limit;
	assign phase_nx = next_phase(phase_q);

	always_comb begin
		run_d        = run_q;
		phase_d      = phase_q;
		start_cnt_d  = start_cnt_q;
		open_d       = open_q;
		last_cmp_d   = last_cmp_q;
		zc_per_d     = zc_per_q;
		last_zc_d    = last_zc_q;
		win_open_d   = win_open_q;
		win_close_d  = win_close_q;
		falling_d    = falling_q;
		valid_seen_d = valid_seen_q;
		last_valid_d = last_valid_q;
		good_d       = good_q;
		lost_d       = lost_q;
		lost_sum_d   = lost_sum_q;
		zc_cnt_d     = zc_cnt_q;
		drive        = 1'b0;
		drv_phase    = phase_q;
		evt          = EVT_NONE;
		cvalid       = 1'b0;
		ct           = '0;
		found        = 1'b0;

		unique case (mode)
			MODE_START: begin
				run_d       = RUN_START;
				phase_d     = 3'd1;
				start_cnt_d = '0;
				drive       = 1'b1;
				drv_phase   = 3'd1;
				ct          = ct_start;
				cvalid      = 1'b1;
				last_cmp_d  = ct_start;
				open_d      = shrink(p0);
			end
			MODE_TIMER: begin
				if (run_q != RUN_STOP) begin
					drive = 1'b1;
				end
				if (run_q == RUN_START) begin
					ct          = ct_open;
					cvalid      = 1'b1;
					last_cmp_d  = ct_open;
					open_d      = shrink(open_q);
					start_cnt_d = cnt_inc;
					phase_d     = phase_nx;
					if (enter_closed) begin
						run_d        = RUN_CLOSED;
						zc_per_d     = zc_init;
						last_zc_d    = now - (zc_init >> 1);
						win_open_d   = now + (zc_init >> 2);
						win_close_d  = now + (zc_init >> 2) + (zc_init >> 1);
						ct           = now + zc_init;
						phase_d      = 3'd1;
						falling_d    = 1'b0;
						valid_seen_d = 1'b0;
						last_valid_d = '1;
						zc_cnt_d     = '0;
					end
				end
			end
			MODE_ADC: begin
				if (run_q == RUN_CLOSED && in_win) begin
					if (late) begin
						good_d     = '0;
						lost_d     = lost_inc;
						lost_sum_d = lost_sum_q + 32'd1;
						if (lost_stop) begin
							lost_d    = '0;
							run_d     = RUN_STOP;
							phase_d   = '0;
							drive     = 1'b1;
							drv_phase = '0;
							evt       = EVT_LOST;
						end else begin
							found = 1'b1;
						end
					end else if (qualified) begin
						if (cross_hit) begin
							good_d = good_inc;
							if (good_inc > 3'(GOOD_MAX)) begin
								good_d = 3'(GOOD_MAX);
								lost_d = '0;
							end
							found = 1'b1;
						end else begin
							last_valid_d = now;
							valid_seen_d = 1'b1;
						end
					end
					if (found) begin
						zc_per_d     = zc_new;
						last_zc_d    = zt;
						win_open_d   = wo_new;
						win_close_d  = wc_new;
						ct           = ct_zc;
						cvalid       = 1'b1;
						falling_d    = !falling_q;
						phase_d      = phase_nx;
						valid_seen_d = 1'b0;
						last_valid_d = '1;
						zc_cnt_d     = zc_inc;
						evt          = EVT_ZC;
						drv_phase    = phase_nx;
						if (at_limit) begin
							lost_d    = '0;
							run_d     = RUN_STOP;
							phase_d   = '0;
							drive     = 1'b1;
							evt       = EVT_LIMIT;
							drv_phase = '0;
						end
					end
				end
			end
			default: ;
		endcase

		res.drive_update  = drive;
		res.phase         = drv_phase;
		res.high_side     = high_side_of(drv_phase);
		res.compare_valid = cvalid;
		res.compare_time  = cvalid ? 32'(ct) : 32'd0;
		res.motor_state   = run_d;
		res.event_code    = evt;
		res.lost_total    = lost_sum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= RUN_STOP;
			phase_q      <= '0;
			start_cnt_q  <= '0;
			open_q       <= '0;
			last_cmp_q   <= '0;
			zc_per_q     <= '0;
			last_zc_q    <= '0;
			win_open_q   <= '0;
			win_close_q  <= '0;
			falling_q    <= 1'b0;
			valid_seen_q <= 1'b0;
			last_valid_q <= '1;
			good_q       <= '0;
			lost_q       <= '0;
			lost_sum_q   <= '0;
			zc_cnt_q     <= '0;
		end else if (adv) begin
			run_q        <= run_d;
			phase_q      <= phase_d;
			start_cnt_q  <= start_cnt_d;
			open_q       <= open_d;
			last_cmp_q   <= last_cmp_d;
			zc_per_q     <= zc_per_d;
			last_zc_q    <= last_zc_d;
			win_open_q   <= win_open_d;
			win_close_q  <= win_close_d;
			falling_q    <= falling_d;
			valid_seen_q <= valid_seen_d;
			last_valid_q <= last_valid_d;
			good_q       <= good_d;
			lost_q       <= lost_d;
			lost_sum_q   <= lost_sum_d;
			zc_cnt_q     <= zc_cnt_d;
		end
	end

	`ASSERT_CLK(a_fault_stops, clk, arst_n, (adv && (res.event_code == EVT_LOST || res.event_code == EVT_LIMIT)) |=> (run_q == RUN_STOP && phase_q == 3'd0), "stop event left motor running")
	`ASSERT_CLK(a_phase_off_iff_stop, clk, arst_n, (run_q == RUN_STOP) == (phase_q == 3'd0), "phase and run state disagree")
	`ASSERT_NEVER(a_lost_bound, clk, arst_n, lost_q > 4'(LOST_MAX), "lost window count past stop bound")
	`ASSERT_NEVER(a_good_bound, clk, arst_n, good_q > 3'(GOOD_MAX), "good crossing count past saturation")
	`ASSERT_CLK(a_hold_on_stall, clk, arst_n, !adv |=> ($stable(run_q) && $stable(lost_sum_q) && $stable(zc_cnt_q)), "state moved without a transfer")

endmodule

[sv/bldc_sensorless_commutator.sv]
// Top level of the sensorless BLDC commutator: input stage, result stage, handshakes.
// Depends on bsc_pkg, bsc_cfg and bsc_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a start command, a
//   commutation timer event or an ADC sample set, selected by mode, with the
//   current time now. Every transferred item yields exactly one result on the
//   output channel (out_valid/out_ready): drive pattern, next compare time,
//   motor state, event code and running lost-window total.
//   Output: an item is held in the input stage, its result is registered
//   in the result stage and waits there until taken.
//   Throughput: one item per cycle while out_ready holds; the commutation state
//   is updated as an item moves from the input stage to the result stage.
//   Receiver stall: the result stage holds, the input stage keeps one more
//   item, then in_ready drops until out_ready returns.
//   Reset: both stages empty, motor stopped, phase off, counters cleared,
//   configuration registers back to their defaults.
//   Configuration: cfg_we/cfg_index/cfg_data, one register per cycle, written
//   while no item is in flight.
module bldc_sensorless_commutator #(
	parameter int TIME_BITS = bsc_pkg::DEF_TIME_BITS,
	parameter int ADC_BITS  = bsc_pkg::DEF_ADC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic [TIME_BITS-1:0]               now,
	input  logic [ADC_BITS-1:0]                volt_a,
	input  logic [ADC_BITS-1:0]                volt_b,
	input  logic [ADC_BITS-1:0]                volt_c,
	input  logic [ADC_BITS-1:0]                supply_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               drive_update,
	output logic [2:0]                         phase,
	output logic [2:0]                         high_side,
	output logic                               compare_valid,
	output logic [31:0]                        compare_time,
	output logic [1:0]                         motor_state,
	output logic [1:0]                         event_code,
	output logic [31:0]                        lost_total
);
	import bsc_pkg::*;

	cfg_t cfg;
	res_t res;

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [ADC_BITS-1:0]  volt_a_s1, volt_b_s1, volt_c_s1, supply_s1;
	logic                 valid_s2;
	res_t                 res_s2;
	logic                 adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	bsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsc_core #(
		.TIME_BITS (TIME_BITS),
		.ADC_BITS  (ADC_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.adv           (adv),
		.mode          (mode_s1),
		.now           (now_s1),
		.volt_a        (volt_a_s1),
		.volt_b        (volt_b_s1),
		.volt_c        (volt_c_s1),
		.supply_sample (supply_s1),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			now_s1    <= now;
			volt_a_s1 <= volt_a;
			volt_b_s1 <= volt_b;
			volt_c_s1 <= volt_c;
			supply_s1 <= supply_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign drive_update  = res_s2.drive_update;
	assign phase         = res_s2.phase;
	assign high_side     = res_s2.high_side;
	assign compare_valid = res_s2.compare_valid;
	assign compare_time  = res_s2.compare_time;
	assign motor_state   = res_s2.motor_state;
	assign event_code    = res_s2.event_code;
	assign lost_total    = res_s2.lost_total;

endmodule
